// File: sv/aesbm_pkg.sv
// Shared types, tables and round helper functions for the AES-128 block mode engine.
// No dependencies; the round, key store and top-level files take names from here by scope.
package aesbm_pkg;

  typedef logic [0:255][7:0] byte_tbl_t;

  localparam byte_tbl_t SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Built at elaboration from the forward table.
  function automatic byte_tbl_t gen_inv_sbox();
    byte_tbl_t t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = i[7:0];
    end
    return t;
  endfunction

  localparam byte_tbl_t INV_SBOX = gen_inv_sbox();

  localparam logic [0:9][7:0] RCON = {
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam int unsigned NUM_RK = 11;
  localparam int unsigned LAST_ROUND = 10;
  localparam int unsigned BLK_BYTES = 16;
  localparam logic [127:0] CMAC_RB = 128'h87;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    MODE_ECB_ENC = 3'd0,
    MODE_ECB_DEC = 3'd1,
    MODE_CBC_ENC = 3'd2,
    MODE_CBC_DEC = 3'd3,
    MODE_CMAC_GEN = 3'd4,
    MODE_CMAC_VER = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_KEY_HI = 3'd0,
    REG_KEY_LO = 3'd1,
    REG_IV_HI = 3'd2,
    REG_IV_LO = 3'd3,
    REG_MODE = 3'd4,
    REG_TAG_BYTES = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    ST_KEYX,
    ST_SUBK,
    ST_IDLE,
    ST_RUN
  } state_e;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] getb(input logic [127:0] s, input int unsigned i);
    return s[127 - 8*i -: 8];
  endfunction

  // One key schedule step from the previous round key.
  function automatic logic [127:0] next_rk(input logic [127:0] p, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] q;
    t = {SBOX[getb(p, 13)] ^ rc, SBOX[getb(p, 14)], SBOX[getb(p, 15)], SBOX[getb(p, 12)]};
    q[127:96] = p[127:96] ^ t;
    q[95:64] = p[95:64] ^ q[127:96];
    q[63:32] = p[63:32] ^ q[95:64];
    q[31:0] = p[31:0] ^ q[63:32];
    return q;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? CMAC_RB : 128'h0);
  endfunction

endpackage

// File: sv/aesbm_round.sv
// One AES-128 round, forward or inverse, shared by every round pass of the sequencer.
// Depends on aesbm_pkg for the tables and helpers.
module aesbm_round (
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  input  logic         dec_i,
  input  logic         final_i,
  output logic [127:0] state_o
);

  logic [127:0] sub_s;
  logic [127:0] mix_s;
  logic [127:0] inv_s;
  logic [127:0] inv_k;
  logic [127:0] imix_s;

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all, b0, b1, b2, b3;
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        sub_s[127 - 8*(c*4+w) -: 8] =
          aesbm_pkg::SBOX[aesbm_pkg::getb(state_i, ((c + w) % 4) * 4 + w)];
        inv_s[127 - 8*(c*4+w) -: 8] =
          aesbm_pkg::INV_SBOX[aesbm_pkg::getb(state_i, ((c + 4 - w) % 4) * 4 + w)];
      end
    end
    inv_k = inv_s ^ key_i;
    for (int c = 0; c < 4; c++) begin
      a0 = aesbm_pkg::getb(sub_s, c*4);
      a1 = aesbm_pkg::getb(sub_s, c*4+1);
      a2 = aesbm_pkg::getb(sub_s, c*4+2);
      a3 = aesbm_pkg::getb(sub_s, c*4+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      mix_s[127 - 32*c -: 32] = {a0 ^ all ^ aesbm_pkg::xt(a0 ^ a1),
                                 a1 ^ all ^ aesbm_pkg::xt(a1 ^ a2),
                                 a2 ^ all ^ aesbm_pkg::xt(a2 ^ a3),
                                 a3 ^ all ^ aesbm_pkg::xt(a3 ^ a0)};
      for (int j = 0; j < 4; j++) begin
        x2[j] = aesbm_pkg::xt(aesbm_pkg::getb(inv_k, c*4+j));
        x4[j] = aesbm_pkg::xt(x2[j]);
        x8[j] = aesbm_pkg::xt(x4[j]);
      end
      b0 = aesbm_pkg::getb(inv_k, c*4);
      b1 = aesbm_pkg::getb(inv_k, c*4+1);
      b2 = aesbm_pkg::getb(inv_k, c*4+2);
      b3 = aesbm_pkg::getb(inv_k, c*4+3);
      // 14, 11, 13, 9 as sums of doublings
      imix_s[127 - 32*c -: 32] = {
        (x8[0]^x4[0]^x2[0]) ^ (x8[1]^x2[1]^b1) ^ (x8[2]^x4[2]^b2) ^ (x8[3]^b3),
        (x8[0]^b0) ^ (x8[1]^x4[1]^x2[1]) ^ (x8[2]^x2[2]^b2) ^ (x8[3]^x4[3]^b3),
        (x8[0]^x4[0]^b0) ^ (x8[1]^b1) ^ (x8[2]^x4[2]^x2[2]) ^ (x8[3]^x2[3]^b3),
        (x8[0]^x2[0]^b0) ^ (x8[1]^x4[1]^b1) ^ (x8[2]^b2) ^ (x8[3]^x4[3]^x2[3])};
    end
  end

  always_comb begin
    if (dec_i) begin
      state_o = final_i ? inv_k : imix_s;
    end else begin
      state_o = (final_i ? sub_s : mix_s) ^ key_i;
    end
  end

endmodule

// File: sv/aesbm_keys.sv
// Round key store with the key schedule step that fills it one key a cycle.
// Depends on aesbm_pkg for the schedule function and round constants.
module aesbm_keys (
  input  logic         clk_i,
  input  logic         we_i,
  input  logic [3:0]   waddr_i,
  input  logic [127:0] key_i,
  input  logic [3:0]   raddr_i,
  output logic [127:0] rk_o
);

  logic [127:0] mem_q [aesbm_pkg::NUM_RK];
  logic [127:0] prev_q;
  logic [127:0] wdata;
  logic [127:0] rk_q;

  always_comb begin
    if (waddr_i == 4'd0) begin
      wdata = key_i;
    end else begin
      wdata = aesbm_pkg::next_rk(prev_q, aesbm_pkg::RCON[waddr_i - 4'd1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata;
      prev_q <= wdata;
    end
    rk_q <= mem_q[raddr_i];
  end

  assign rk_o = rk_q;

endmodule

// File: sv/aes128_block_mode_engine_unit.sv
// AES-128 ECB/CBC/CMAC engine: one item enters, a key whitening pass and ten passes of a shared round unit follow.
// A new item is accepted only in idle, once the previous one is done; the single round unit and its key store
// set the pace, and a stalled result holds the last pass until the output register frees.
// Reset and every key write run the key schedule and then subkey derivation;
// no item is accepted until both are done.
// Depends on aesbm_pkg, aesbm_round and aesbm_keys.
module aes128_block_mode_engine_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // block_high[63:0], block_low[127:64], valid_bytes[132:128],
  // expected_tag_high[196:133], expected_tag_low[260:197], zero fill
  input  logic [263:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // first_block
  input  logic         s_axis_tlast,  // last_block
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_high[63:0], result_low[127:64]
  output logic [127:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // is_tag[0], tag_match[1]
);

  aesbm_pkg::state_e state_q, state_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [127:0] key_q, iv_q;
  logic [2:0]   mode_q;
  logic [4:0]   tagb_q;
  logic [127:0] st_q, st_d, post_q, post_d, chain_q, chain_d, k1_q, k1_d, k2_q, k2_d;
  logic [127:0] exp_q, exp_d;
  logic         last_q, last_d;
  logic         mv_q, mv_d;
  logic [127:0] md_q, md_d;
  logic [1:0]   mu_q, mu_d;

  logic         cfg_we, key_we, acc, is_dec, rk_we, finish, out_free;
  logic [3:0]   raddr;
  logic [127:0] rk, round_out;
  logic [2:0]   reg_idx;

  logic [127:0] blk, csel, padded, xin, tag, mask;
  logic [4:0]   vb, tb;

  assign pready = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we = psel && penable && pwrite;
  assign key_we = cfg_we &&
                  (reg_idx == aesbm_pkg::REG_KEY_HI || reg_idx == aesbm_pkg::REG_KEY_LO);

  always_comb begin
    unique case (aesbm_pkg::reg_e'(reg_idx))
      aesbm_pkg::REG_KEY_HI:    prdata = key_q[127:64];
      aesbm_pkg::REG_KEY_LO:    prdata = key_q[63:0];
      aesbm_pkg::REG_IV_HI:     prdata = iv_q[127:64];
      aesbm_pkg::REG_IV_LO:     prdata = iv_q[63:0];
      aesbm_pkg::REG_MODE:      prdata = {61'd0, mode_q};
      aesbm_pkg::REG_TAG_BYTES: prdata = {59'd0, tagb_q};
      default:                  prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q <= '0;
      mode_q <= aesbm_pkg::MODE_ECB_ENC;
      tagb_q <= 5'd16;
    end else if (cfg_we) begin
      unique case (reg_idx)
        aesbm_pkg::REG_KEY_HI:    key_q[127:64] <= pwdata;
        aesbm_pkg::REG_KEY_LO:    key_q[63:0] <= pwdata;
        aesbm_pkg::REG_IV_HI:     iv_q[127:64] <= pwdata;
        aesbm_pkg::REG_IV_LO:     iv_q[63:0] <= pwdata;
        aesbm_pkg::REG_MODE:      mode_q <= pwdata[2:0];
        aesbm_pkg::REG_TAG_BYTES: tagb_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  assign is_dec = (state_q == aesbm_pkg::ST_RUN || state_q == aesbm_pkg::ST_IDLE) &&
                  (mode_q == aesbm_pkg::MODE_ECB_DEC || mode_q == aesbm_pkg::MODE_CBC_DEC);
  assign s_axis_tready = (state_q == aesbm_pkg::ST_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !mv_q || m_axis_tready;
  assign finish = (cnt_q == 4'(aesbm_pkg::LAST_ROUND));
  assign rk_we = (state_q == aesbm_pkg::ST_KEYX);

  // Prefetch the key for the next pass; read data arrives in the next cycle.
  // Hold the last round's key while a finished item waits for the output.
  always_comb begin
    raddr = 4'd0;
    if (state_q == aesbm_pkg::ST_IDLE) begin
      raddr = is_dec ? 4'(aesbm_pkg::LAST_ROUND) : 4'd0;
    end else if (state_q != aesbm_pkg::ST_KEYX) begin
      if (finish) begin
        raddr = is_dec ? 4'd0 : 4'(aesbm_pkg::LAST_ROUND);
      end else begin
        raddr = is_dec ? 4'd9 - cnt_q : cnt_q + 4'd1;
      end
    end
  end

  aesbm_keys u_keys (
    .clk_i  (clk_i),
    .we_i   (rk_we),
    .waddr_i(cnt_q),
    .key_i  (key_q),
    .raddr_i(raddr),
    .rk_o   (rk)
  );

  aesbm_round u_round (
    .state_i(st_q),
    .key_i  (rk),
    .dec_i  (is_dec),
    .final_i(finish),
    .state_o(round_out)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    unique case (state_q)
      aesbm_pkg::ST_KEYX: begin
        cnt_d = cnt_q + 4'd1;
        if (finish) begin
          state_d = aesbm_pkg::ST_SUBK;
          cnt_d = 4'd0;
        end
      end
      aesbm_pkg::ST_SUBK: begin
        cnt_d = cnt_q + 4'd1;
        if (finish) begin
          state_d = aesbm_pkg::ST_IDLE;
        end
      end
      aesbm_pkg::ST_IDLE: begin
        cnt_d = 4'd0;
        if (acc && mode_q <= aesbm_pkg::MODE_CMAC_VER) begin
          state_d = aesbm_pkg::ST_RUN;
        end
      end
      aesbm_pkg::ST_RUN: begin
        if (!finish) begin
          cnt_d = cnt_q + 4'd1;
        end else if (out_free) begin
          state_d = aesbm_pkg::ST_IDLE;
        end
      end
      default: state_d = aesbm_pkg::ST_IDLE;
    endcase
    if (key_we) begin
      state_d = aesbm_pkg::ST_KEYX;
      cnt_d = 4'd0;
    end
  end

  // Input preparation.
  always_comb begin
    blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    vb = s_axis_tdata[132:128];
    if (mode_q == aesbm_pkg::MODE_CBC_ENC || mode_q == aesbm_pkg::MODE_CBC_DEC) begin
      csel = s_axis_tuser ? iv_q : chain_q;
    end else begin
      csel = s_axis_tuser ? 128'h0 : chain_q;
    end
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < vb) begin
        padded[127 - 8*i -: 8] = blk[127 - 8*i -: 8];
      end else if (5'(i) == vb) begin
        padded[127 - 8*i -: 8] = aesbm_pkg::PAD_BYTE;
      end else begin
        padded[127 - 8*i -: 8] = 8'h00;
      end
    end
    unique case (mode_q)
      aesbm_pkg::MODE_CBC_ENC: xin = blk ^ csel;
      aesbm_pkg::MODE_CMAC_GEN, aesbm_pkg::MODE_CMAC_VER: begin
        if (!s_axis_tlast) begin
          xin = blk ^ csel;
        end else if (vb[4]) begin
          xin = blk ^ k1_q ^ csel;
        end else begin
          xin = padded ^ k2_q ^ csel;
        end
      end
      default: xin = blk;
    endcase
  end

  // Tag truncation.
  always_comb begin
    tb = (tagb_q > 5'(aesbm_pkg::BLK_BYTES)) ? 5'(aesbm_pkg::BLK_BYTES) : tagb_q;
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8*i -: 8] = (5'(i) < tb) ? 8'hff : 8'h00;
    end
    tag = round_out & mask;
  end

  // Datapath and output register.
  always_comb begin
    st_d = st_q;
    post_d = post_q;
    chain_d = chain_q;
    k1_d = k1_q;
    k2_d = k2_q;
    exp_d = exp_q;
    last_d = last_q;
    mv_d = mv_q && !m_axis_tready;
    md_d = md_q;
    mu_d = mu_q;
    unique case (state_q)
      aesbm_pkg::ST_KEYX: st_d = '0;
      aesbm_pkg::ST_SUBK: begin
        st_d = (cnt_q == 4'd0) ? st_q ^ rk : round_out;
        if (finish) begin
          k1_d = aesbm_pkg::dbl(round_out);
          k2_d = aesbm_pkg::dbl(aesbm_pkg::dbl(round_out));
        end
      end
      aesbm_pkg::ST_IDLE: begin
        if (acc) begin
          st_d = xin;
          exp_d = {s_axis_tdata[196:133], s_axis_tdata[260:197]};
          last_d = s_axis_tlast;
          post_d = (mode_q == aesbm_pkg::MODE_CBC_DEC) ? csel : 128'h0;
          if (mode_q == aesbm_pkg::MODE_CBC_DEC) begin
            chain_d = blk;
          end
        end
      end
      aesbm_pkg::ST_RUN: begin
        if (!finish) begin
          st_d = (cnt_q == 4'd0) ? st_q ^ rk : round_out;
        end else if (out_free) begin
          unique case (mode_q)
            aesbm_pkg::MODE_CMAC_GEN, aesbm_pkg::MODE_CMAC_VER: begin
              if (last_q) begin
                chain_d = '0;
                mv_d = 1'b1;
                md_d = tag;
                mu_d = {(mode_q == aesbm_pkg::MODE_CMAC_VER) && ((tag ^ exp_q) & mask) == '0,
                        1'b1};
              end else begin
                chain_d = round_out;
              end
            end
            default: begin
              if (mode_q == aesbm_pkg::MODE_CBC_ENC) begin
                chain_d = round_out;
              end
              mv_d = 1'b1;
              md_d = round_out ^ post_q;
              mu_d = 2'b00;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesbm_pkg::ST_KEYX;
      cnt_q <= '0;
      mv_q <= 1'b0;
      chain_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      mv_q <= mv_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    post_q <= post_d;
    k1_q <= k1_d;
    k2_q <= k2_d;
    exp_q <= exp_d;
    last_q <= last_d;
    md_q <= md_d;
    mu_q <= mu_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata = {md_q[63:0], md_q[127:64]};
  assign m_axis_tuser = mu_q;

endmodule

// File: sv/aesbm_chk.sv
// Port-level checks for the AES-128 block mode engine, bound to its top level.
// Depends only on the top level's ports.
module aesbm_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_match_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("tag match without tag");

  a_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("ready before key schedule done");

endmodule

bind aes128_block_mode_engine_unit aesbm_chk u_chk (.*);
